// File: src/l3d_pkg.sv
// shared types and constants for the 3d lut trilinear color map
// no dependencies
`timescale 1ns / 1ps

package l3d_pkg;

  localparam int MAX_LUT_SIZE = 64;
  localparam int STORE_DEPTH  = MAX_LUT_SIZE * MAX_LUT_SIZE * MAX_LUT_SIZE;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int SIZE_W       = 7;

  // total corner weight, 255^3, and its scaled reciprocal floor(2^40 / 255^3)
  localparam logic [31:0] W_SCALE     = 32'd16581375;
  localparam logic [16:0] RECIP       = 17'd66310;
  localparam int          RECIP_SHIFT = 40;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 7'(MAX_LUT_SIZE);

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] entry_index;
    logic [7:0]       entry_red;
    logic [7:0]       entry_green;
    logic [7:0]       entry_blue;
    logic [7:0]       pixel_red;
    logic [7:0]       pixel_green;
    logic [7:0]       pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

endpackage

// File: src/lut3d_trilinear_color_map.sv
// 3d color lookup table in hald layout with trilinear interpolation
// depends on l3d_pkg
`timescale 1ns / 1ps

// channel  ports                            transfer when
// input    start, busy, in_data             start high and busy low
// result   out_valid, out_data              out_valid high, one cycle
// config   cfg_we, cfg_wdata                cfg_we high
//
// one item enters every cycle, busy is always low
// a pixel's result passes stage registers 1 to 10 and then the output register before its strobe; writes give none
// table writes land in the same stage as the corner reads, so order is kept
// the table is four copies with two read ports each, for eight corners a cycle
// reset clears control state and lut_size only; the table is undefined until written

module lut3d_trilinear_color_map (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  l3d_pkg::in_item_t    in_data,
  output logic                 out_valid,
  output l3d_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [l3d_pkg::SIZE_W-1:0] cfg_wdata
);

  import l3d_pkg::*;

  // config register and effective size
  logic [SIZE_W-1:0] lut_size_r;
  logic [SIZE_W-1:0] n_eff;
  logic [5:0]        n_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      lut_size_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (lut_size_r < SIZE_MIN) begin
      n_eff = SIZE_MIN;
    end else if (lut_size_r > SIZE_MAX) begin
      n_eff = SIZE_MAX;
    end else begin
      n_eff = lut_size_r;
    end
    n_m1 = 6'(n_eff - 7'd1);
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: scale each channel by n-1
  logic              v1_r, op1_r;
  logic [IDX_W-1:0]  wi1_r;
  logic [23:0]       wd1_r;
  logic [13:0]       sc1_r [3];
  logic [13:0]       sc1_nxt [3];
  logic [SIZE_W-1:0] n1_r;
  logic [12:0]       nn1_r;
  logic [12:0]       nn1_nxt;

  always_comb begin
    sc1_nxt[0] = 14'(in_data.pixel_red)   * 14'(n_m1);
    sc1_nxt[1] = 14'(in_data.pixel_green) * 14'(n_m1);
    sc1_nxt[2] = 14'(in_data.pixel_blue)  * 14'(n_m1);
    nn1_nxt    = 13'(n_eff) * 13'(n_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    op1_r <= in_data.opcode;
    wi1_r <= in_data.entry_index;
    wd1_r <= {in_data.entry_blue, in_data.entry_green, in_data.entry_red};
    sc1_r <= sc1_nxt;
    n1_r  <= n_eff;
    nn1_r <= nn1_nxt;
  end

  // stage 2: split into cell and fraction in 255ths, clamp upper neighbor
  logic              v2_r, op2_r;
  logic [IDX_W-1:0]  wi2_r;
  logic [23:0]       wd2_r;
  logic [5:0]        lo2_r [3];
  logic [5:0]        hi2_r [3];
  logic [7:0]        fr2_r [3];
  logic [5:0]        lo2_nxt [3];
  logic [5:0]        hi2_nxt [3];
  logic [7:0]        fr2_nxt [3];
  logic [SIZE_W-1:0] n2_r;
  logic [12:0]       nn2_r;

  always_comb begin
    logic [14:0] q;
    logic [13:0] q255;
    logic [5:0]  top;
    top = 6'(n1_r - 7'd1);
    for (int a = 0; a < 3; a++) begin
      // floor(s / 255) for s below 2^16 - 1
      q          = (15'(sc1_r[a]) + 15'(sc1_r[a] >> 8) + 15'd1) >> 8;
      lo2_nxt[a] = q[5:0];
      q255       = (14'(q[5:0]) << 8) - 14'(q[5:0]);
      fr2_nxt[a] = 8'(sc1_r[a] - q255);
      hi2_nxt[a] = (q[5:0] < top) ? q[5:0] + 6'd1 : q[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    op2_r <= op1_r;
    wi2_r <= wi1_r;
    wd2_r <= wd1_r;
    lo2_r <= lo2_nxt;
    hi2_r <= hi2_nxt;
    fr2_r <= fr2_nxt;
    n2_r  <= n1_r;
    nn2_r <= nn1_r;
  end

  // stage 3: green and blue index terms, axis weights
  logic             v3_r, op3_r;
  logic [IDX_W-1:0] wi3_r;
  logic [23:0]      wd3_r;
  logic [5:0]       rc3_r [2];
  logic [12:0]      gt3_r [2];
  logic [IDX_W-1:0] bt3_r [2];
  logic [7:0]       wr3_r [2];
  logic [7:0]       wg3_r [2];
  logic [7:0]       wb3_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    op3_r    <= op2_r;
    wi3_r    <= wi2_r;
    wd3_r    <= wd2_r;
    rc3_r[0] <= lo2_r[0];
    rc3_r[1] <= hi2_r[0];
    gt3_r[0] <= 13'(n2_r) * 13'(lo2_r[1]);
    gt3_r[1] <= 13'(n2_r) * 13'(hi2_r[1]);
    bt3_r[0] <= IDX_W'(nn2_r) * IDX_W'(lo2_r[2]);
    bt3_r[1] <= IDX_W'(nn2_r) * IDX_W'(hi2_r[2]);
    wr3_r[0] <= 8'd255 - fr2_r[0];
    wr3_r[1] <= fr2_r[0];
    wg3_r[0] <= 8'd255 - fr2_r[1];
    wg3_r[1] <= fr2_r[1];
    wb3_r[0] <= 8'd255 - fr2_r[2];
    wb3_r[1] <= fr2_r[2];
  end

  // stage 4: table write or eight corner reads, red-green weight products
  logic [IDX_W-1:0] addr4_nxt [8];
  logic             wr_en;
  logic [23:0]      mem0 [STORE_DEPTH];
  logic [23:0]      mem1 [STORE_DEPTH];
  logic [23:0]      mem2 [STORE_DEPTH];
  logic [23:0]      mem3 [STORE_DEPTH];
  logic [23:0]      ent4_r [8];
  logic [15:0]      rg4_r [4];
  logic [7:0]       wb4_r [2];
  logic             v4_r;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      addr4_nxt[k] = IDX_W'(rc3_r[k & 1]) + IDX_W'(gt3_r[(k >> 1) & 1]) + bt3_r[k >> 2];
    end
  end

  assign wr_en = v3_r && (op3_r == OP_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem0[wi3_r] <= wd3_r;
      mem1[wi3_r] <= wd3_r;
      mem2[wi3_r] <= wd3_r;
      mem3[wi3_r] <= wd3_r;
    end
    ent4_r[0] <= mem0[addr4_nxt[0]];
    ent4_r[1] <= mem0[addr4_nxt[1]];
    ent4_r[2] <= mem1[addr4_nxt[2]];
    ent4_r[3] <= mem1[addr4_nxt[3]];
    ent4_r[4] <= mem2[addr4_nxt[4]];
    ent4_r[5] <= mem2[addr4_nxt[5]];
    ent4_r[6] <= mem3[addr4_nxt[6]];
    ent4_r[7] <= mem3[addr4_nxt[7]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r && (op3_r == OP_PIXEL);
    end
    for (int j = 0; j < 4; j++) begin
      rg4_r[j] <= 16'(wr3_r[j & 1]) * 16'(wg3_r[j >> 1]);
    end
    wb4_r <= wb3_r;
  end

  // stage 5: full corner weights
  logic        v5_r;
  logic [23:0] w5_r [8];
  logic [23:0] ent5_r [8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    for (int k = 0; k < 8; k++) begin
      w5_r[k] <= 24'(rg4_r[k & 3]) * 24'(wb4_r[k >> 2]);
    end
    ent5_r <= ent4_r;
  end

  // stage 6: entry times weight per channel and corner
  logic        v6_r;
  logic [31:0] prod6_r [3][8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 8; k++) begin
        prod6_r[c][k] <= 32'(ent5_r[k][8*c +: 8]) * 32'(w5_r[k]);
      end
    end
  end

  // stage 7: pairwise sums
  logic        v7_r;
  logic [31:0] pair7_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    for (int c = 0; c < 3; c++) begin
      for (int m = 0; m < 4; m++) begin
        pair7_r[c][m] <= prod6_r[c][2*m] + prod6_r[c][2*m+1];
      end
    end
  end

  // stage 8: channel totals, in units of 1/255^3
  logic        v8_r;
  logic [31:0] acc8_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    for (int c = 0; c < 3; c++) begin
      acc8_r[c] <= (pair7_r[c][0] + pair7_r[c][1]) + (pair7_r[c][2] + pair7_r[c][3]);
    end
  end

  // stage 9: reciprocal multiply, estimate is the quotient or one below
  logic        v9_r;
  logic [48:0] mq9_r [3];
  logic [31:0] acc9_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
    for (int c = 0; c < 3; c++) begin
      mq9_r[c] <= 49'(acc8_r[c]) * 49'(RECIP);
    end
    acc9_r <= acc8_r;
  end

  // stage 10: back-multiply the estimate
  logic        v10_r;
  logic [7:0]  qe10_r [3];
  logic [31:0] t10_r [3];
  logic [31:0] acc10_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= v9_r;
    end
    for (int c = 0; c < 3; c++) begin
      qe10_r[c] <= mq9_r[c][RECIP_SHIFT +: 8];
      t10_r[c]  <= 32'(mq9_r[c][RECIP_SHIFT +: 8]) * W_SCALE;
    end
    acc10_r <= acc9_r;
  end

  // output: one correction step and saturate
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic [7:0] q_nxt [3];

  always_comb begin
    logic [31:0] rem;
    logic [8:0]  q;
    for (int c = 0; c < 3; c++) begin
      rem = acc10_r[c] - t10_r[c];
      q   = (rem >= W_SCALE) ? 9'(qe10_r[c]) + 9'd1 : 9'(qe10_r[c]);
      q_nxt[c] = q[8] ? 8'd255 : q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v10_r;
    end
    out_data_r.out_red   <= q_nxt[0];
    out_data_r.out_green <= q_nxt[1];
    out_data_r.out_blue  <= q_nxt[2];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks on internal arithmetic and sequencing
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (fr2_r[0] < 8'd255) && (fr2_r[1] < 8'd255) && (fr2_r[2] < 8'd255))
    else $error("fraction out of range");

  a_est_low: assert property (@(posedge clk) disable iff (!rst_n)
    v10_r |-> (acc10_r[0] >= t10_r[0]) && (acc10_r[1] >= t10_r[1]) &&
              (acc10_r[2] >= t10_r[2]))
    else $error("quotient estimate too high");

  a_out_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> $past(v3_r) && ($past(op3_r) == OP_PIXEL))
    else $error("result strobe without pixel transfer");

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> ($past(w5_r[0]) + $past(w5_r[1]) + $past(w5_r[2]) + $past(w5_r[3]) +
              $past(w5_r[4]) + $past(w5_r[5]) + $past(w5_r[6]) + $past(w5_r[7]))
             == 24'(W_SCALE))
    else $error("corner weights do not sum to full scale");

endmodule
